// ----- hdl/i2a_pkg.sv -----
// Package for the integer-to-ASCII converter: widths, mode codes,
// character codes, state types and the digit-to-character function.
// No dependencies.
package i2a_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned NumDec   = 10;
  localparam int unsigned DigitsW  = NumDec * DigitW;
  localparam int unsigned CntW     = 4;
  localparam int unsigned BitCntW  = 5;

  localparam logic [CntW-1:0] NumDecDigits = 4'd10;
  localparam logic [CntW-1:0] NumHexDigits = 4'd8;

  localparam logic [1:0] FuncSignedDec = 2'd0;
  localparam logic [1:0] FuncHex       = 2'd2;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharA     = 8'h41;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } i2a_state_e;

  typedef enum logic [1:0] {
    EmIdle,
    EmSign,
    EmSkip,
    EmEmit
  } i2a_emit_state_e;

  typedef struct packed {
    logic            load;
    logic            neg;
    logic [CntW-1:0] ndig;
  } i2a_emit_cmd_t;

  function automatic logic [7:0] digit_char(input logic [DigitW-1:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CharZero + {4'h0, d};
    end else begin
      r = CharA + {4'h0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ----- hdl/i2a_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on i2a_pkg.
module i2a_dabble (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [i2a_pkg::WordW-1:0]    bin_i,
  output logic                         done_o,
  output logic [i2a_pkg::DigitsW-1:0]  bcd_o
);

  logic [i2a_pkg::WordW-1:0]   bin_q, bin_d;
  logic [i2a_pkg::DigitsW-1:0] bcd_q, bcd_d;
  logic [i2a_pkg::DigitsW-1:0] adj;
  logic [i2a_pkg::BitCntW-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < i2a_pkg::NumDec; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = bin_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[i2a_pkg::DigitsW-2:0], bin_q[i2a_pkg::WordW-1]};
      bin_d = {bin_q[i2a_pkg::WordW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q)
    else $error("dabble did not start");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && bcd_q[i2a_pkg::DigitsW-1 -: 4] <= 4'd9)
    else $error("dabble done while busy or top digit out of range");

endmodule

// ----- hdl/i2a_emit.sv -----
// Character emitter: shifts out one digit per cycle while the output register can take it,
// drops leading zeros, prefixes a minus sign and holds each character in an output register.
// Depends on i2a_pkg.
module i2a_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  i2a_pkg::i2a_emit_cmd_t       cmd_i,
  input  logic [i2a_pkg::DigitsW-1:0]  digits_i,
  output logic                         idle_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_char_o,
  output logic                         last_char_o
);

  i2a_pkg::i2a_emit_state_e     state_q, state_d;
  logic [i2a_pkg::DigitsW-1:0]  digs_q, digs_d;
  logic [i2a_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                         ovalid_q, ovalid_d;
  logic [7:0]                   ochar_q, ochar_d;
  logic                         olast_q, olast_d;
  logic                         can_load;
  logic [i2a_pkg::DigitW-1:0]   top_dig;

  assign can_load = !ovalid_q || out_ready_i;
  assign top_dig  = digs_q[i2a_pkg::DigitsW-1 -: i2a_pkg::DigitW];

  always_comb begin
    state_d  = state_q;
    digs_d   = digs_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      i2a_pkg::EmIdle: begin
        if (cmd_i.load) begin
          digs_d  = digits_i;
          cnt_d   = cmd_i.ndig;
          state_d = cmd_i.neg ? i2a_pkg::EmSign : i2a_pkg::EmSkip;
        end
      end
      i2a_pkg::EmSign: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          ochar_d  = i2a_pkg::CharMinus;
          olast_d  = 1'b0;
          state_d  = i2a_pkg::EmSkip;
        end
      end
      i2a_pkg::EmSkip: begin
        // Drop one leading zero per cycle, keep at least one digit.
        if (top_dig == '0 && cnt_q > 4'd1) begin
          digs_d = {digs_q[i2a_pkg::DigitsW-i2a_pkg::DigitW-1:0], 4'h0};
          cnt_d  = cnt_q - 1'b1;
        end else begin
          state_d = i2a_pkg::EmEmit;
        end
      end
      i2a_pkg::EmEmit: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          ochar_d  = i2a_pkg::digit_char(top_dig);
          olast_d  = (cnt_q == 4'd1);
          digs_d   = {digs_q[i2a_pkg::DigitsW-i2a_pkg::DigitW-1:0], 4'h0};
          cnt_d    = cnt_q - 1'b1;
          if (cnt_q == 4'd1) begin
            state_d = i2a_pkg::EmIdle;
          end
        end
      end
      default: begin
        state_d = i2a_pkg::EmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= i2a_pkg::EmIdle;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digs_q  <= digs_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign idle_o      = (state_q == i2a_pkg::EmIdle);
  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign last_char_o = olast_q;

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == i2a_pkg::EmEmit || state_q == i2a_pkg::EmSkip) |-> cnt_q != '0)
    else $error("emitter running with no digits left");

  a_load_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> cmd_i.ndig != '0)
    else $error("emitter loaded with zero digits");

endmodule

// ----- hdl/int_to_ascii_converter.sv -----
// Integer to ASCII converter: signed decimal, unsigned decimal or upper-case hex.
// Decimal: the bit-serial BCD shifter converts the magnitude, then the emitter puts out an
// optional minus sign, drops leading zeros and emits the digits; the next transaction is
// taken once every character has been queued. Hex: no conversion, the nibbles go straight
// to the emitter. Output stalls delay both; the emitter handles one digit at a time.
// Reset (rst_ni low, asynchronous) returns all control to idle; no data is kept.
module int_to_ascii_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  input  logic [1:0]  func_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_char_o
);

  i2a_pkg::i2a_state_e           state_q, state_d;
  logic                          neg_q, neg_d;
  logic                          in_fire;
  logic                          is_neg;
  logic                          is_hex;
  logic [i2a_pkg::WordW-1:0]     mag;
  logic                          dab_start;
  logic                          dab_done;
  logic [i2a_pkg::DigitsW-1:0]   dab_bcd;
  i2a_pkg::i2a_emit_cmd_t        emit_cmd;
  logic [i2a_pkg::DigitsW-1:0]   emit_digits;
  logic                          emit_idle;

  // Take a new transaction only once the previous one has been handed to the
  // emitter in full; the emitter's output register may still hold its last
  // character, which keeps ordering intact.
  assign in_ready_o = (state_q == i2a_pkg::StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  // Mode three falls through to unsigned decimal.
  assign is_neg = (func_i == i2a_pkg::FuncSignedDec) && value_i[i2a_pkg::WordW-1];
  assign is_hex = (func_i == i2a_pkg::FuncHex);
  // Two's complement negate; the most negative word reads back as 2^31.
  assign mag    = is_neg ? (32'd0 - value_i) : value_i;

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    dab_start   = 1'b0;
    emit_cmd    = '0;
    emit_digits = dab_bcd;
    case (state_q)
      i2a_pkg::StIdle: begin
        if (in_fire) begin
          neg_d = is_neg;
          if (is_hex) begin
            // Hex nibbles are the digits already: hand them straight over.
            emit_cmd.load = 1'b1;
            emit_cmd.neg  = 1'b0;
            emit_cmd.ndig = i2a_pkg::NumHexDigits;
            emit_digits   = {value_i, 8'h00};
            state_d       = i2a_pkg::StEmit;
          end else begin
            dab_start = 1'b1;
            state_d   = i2a_pkg::StConv;
          end
        end
      end
      i2a_pkg::StConv: begin
        // Emitter is idle here: the last transaction left it before StIdle.
        if (dab_done) begin
          emit_cmd.load = 1'b1;
          emit_cmd.neg  = neg_q;
          emit_cmd.ndig = i2a_pkg::NumDecDigits;
          state_d       = i2a_pkg::StEmit;
        end
      end
      i2a_pkg::StEmit: begin
        // Hold until the emitter has queued every character.
        if (emit_idle) begin
          state_d = i2a_pkg::StIdle;
        end
      end
      default: begin
        state_d = i2a_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2a_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
  end

  i2a_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .bin_i   (mag),
    .done_o  (dab_done),
    .bcd_o   (dab_bcd)
  );

  i2a_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (emit_cmd),
    .digits_i    (emit_digits),
    .idle_o      (emit_idle),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cmd.load |-> emit_idle)
    else $error("emitter loaded while busy");

  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dab_done |-> state_q == i2a_pkg::StConv)
    else $error("conversion finished outside the conversion phase");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for int_to_ascii_converter: drives words in all three
// modes and compares every emitted character with an in-bench prediction.
// Depends on i2a_pkg and the int_to_ascii_converter RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode codes that the package leaves unnamed.
  localparam logic [1:0] FuncUnsignedDec = 2'd1;
  localparam logic [1:0] FuncModeThree   = 2'd3;

  // Settle beyond the longest unstalled decimal transaction.
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned RandomItems  = 26;

  localparam logic [31:0] PowTen [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
    32'd10000000, 32'd100000000, 32'd1000000000
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ascii_char_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [31:0] value_i     = '0;
  logic [1:0]  func_i      = i2a_pkg::FuncSignedDec;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_char_o;
  logic        last_char_o;

  // Characters still owed by the converter, oldest first.
  ascii_char_t expected_chars [$];
  int unsigned error_count = 0;

  // Per-cycle idle percentages for the sending and receiving sides.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int_to_ascii_converter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: the slowest legal run is far below this.
  initial begin
    #2_000_000;
    $display("FAIL int_to_ascii_converter");
    $finish;
  end

  // Spell a word the way the converter should: optional sign, then digits
  // most significant first, the last one flagged. Mode three is plain
  // unsigned decimal; the most negative word negates to itself, which read
  // as unsigned is exactly its magnitude.
  function automatic void spell_number(input logic [31:0] word, input logic [1:0] func);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [31:0] rem;
    logic [7:0]  digits [$];
    mag   = word;
    radix = (func == i2a_pkg::FuncHex) ? 32'd16 : 32'd10;
    if (func == i2a_pkg::FuncSignedDec && word[31]) begin
      expected_chars.push_back('{ch: i2a_pkg::CharMinus, last: 1'b0});
      mag = -word;
    end
    do begin
      rem = mag % radix;
      digits.push_front(rem < 32'd10 ? i2a_pkg::CharZero + rem[7:0]
                                     : i2a_pkg::CharA + rem[7:0] - 8'd10);
      mag = mag / radix;
    end while (mag != 0);
    foreach (digits[k]) begin
      expected_chars.push_back('{ch: digits[k], last: (k == digits.size() - 1)});
    end
  endfunction

  // Offer one word; idle first at random, then hold valid and payload until
  // the converter takes the transaction. Valid stays high on return so that
  // back-to-back words need no drop in between.
  task automatic send_word(input logic [31:0] word, input logic [1:0] func);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= word;
    func_i     <= func;
    do @(posedge clk_i); while (!in_ready_o);
    spell_number(word, func);
  endtask

  // Hold off the sender until every owed character has come out.
  task automatic drain_chars();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random words weighted toward digit-count boundaries and sign edges.
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    int unsigned k;
    case ($urandom_range(5))
      0: w = $urandom();
      1: w = $urandom_range(20);
      2: begin
        k = $urandom_range(9);
        w = PowTen[k] + $urandom_range(2) - 1;
      end
      3: w = ($urandom_range(1) ? 32'h8000_0000 : 32'hFFFF_FFFD) + $urandom_range(2);
      4: w = $urandom() >> $urandom_range(31);
      default: w = $urandom() >> ($urandom_range(7) * 4);
    endcase
    return w;
  endfunction

  // Receiver: drop ready at random per cycle, change only on the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted character with the oldest one owed.
  always @(posedge clk_i) begin : check_chars
    ascii_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char %h last %b", $realtime, out_char_o, last_char_o);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char_o !== want.ch) begin
          $display("%0t: char expected %h actual %h", $realtime, want.ch, out_char_o);
          error_count++;
        end
        if (last_char_o !== want.last) begin
          $display("%0t: last flag expected %b actual %b", $realtime, want.last,
                   last_char_o);
          error_count++;
        end
      end
    end
  end

  // Zero must give a lone '0' in signed decimal, unsigned decimal and hex.
  task automatic test_zero();
    send_word(32'd0, i2a_pkg::FuncSignedDec);
    send_word(32'd0, FuncUnsignedDec);
    send_word(32'd0, i2a_pkg::FuncHex);
  endtask

  // All-ones in each mode, the largest positive word in both decimal modes, plus digit-count edges.
  task automatic test_extremes();
    send_word(32'hFFFF_FFFF, i2a_pkg::FuncSignedDec);
    send_word(32'hFFFF_FFFF, FuncUnsignedDec);
    send_word(32'hFFFF_FFFF, i2a_pkg::FuncHex);
    send_word(32'h7FFF_FFFF, i2a_pkg::FuncSignedDec);
    send_word(32'h7FFF_FFFF, FuncUnsignedDec);
    send_word(32'd9, i2a_pkg::FuncSignedDec);
    send_word(32'd10, FuncUnsignedDec);
    send_word(32'd999_999_999, FuncUnsignedDec);
    send_word(32'd1_000_000_000, i2a_pkg::FuncSignedDec);
  endtask

  // The most negative word prints with all eleven characters in signed mode.
  task automatic test_most_negative();
    send_word(32'h8000_0000, i2a_pkg::FuncSignedDec);
    send_word(32'h8000_0000, FuncUnsignedDec);
    send_word(32'h8000_0001, i2a_pkg::FuncSignedDec);
  endtask

  // Every hex digit, letters included, and the one-to-two digit boundary.
  task automatic test_hex_digits();
    send_word(32'h0123_4567, i2a_pkg::FuncHex);
    send_word(32'h89AB_CDEF, i2a_pkg::FuncHex);
    send_word(32'h0000_000F, i2a_pkg::FuncHex);
    send_word(32'h0000_0010, i2a_pkg::FuncHex);
  endtask

  // The spare mode code falls back to unsigned decimal.
  task automatic test_mode_three();
    send_word(32'hFFFF_FFFF, FuncModeThree);
    send_word(32'd0, FuncModeThree);
    send_word(32'h8000_0000, FuncModeThree);
  endtask

  task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (RandomItems) send_word(pick_word(), 2'($urandom_range(3)));
  endtask

  initial begin
    // Hold reset low from time zero, release it on a falling edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 46;
    test_zero();
    test_extremes();
    test_most_negative();
    drain_chars();
    test_hex_digits();
    test_mode_three();

    // Random part: receiver-heavy idling, then sender-heavy, then none.
    test_random(32, 46);
    test_random(46, 32);
    drain_chars();
    test_random(0, 0);

    // Drop valid, wait out the owed characters, then watch for strays.
    drain_chars();
    if (error_count == 0) begin
      $display("PASS int_to_ascii_converter");
    end else begin
      $display("FAIL int_to_ascii_converter");
    end
    $finish;
  end

endmodule
